// ===== rtl/core/counting_semaphore_fifo_waiters_unit_assert.svh =====
// Assertion macros shared by the semaphore RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in the using module.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define CSFW_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CSFW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csfw_pkg.sv =====
// Shared constants, types and helpers for the counting semaphore with waiter queue.
// No dependencies.
package csfw_pkg;

    localparam int QDEPTH  = 32;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int FILL_W  = $clog2(QDEPTH + 1);
    localparam int ID_W    = 8;
    localparam int CNT_W   = 32;
    localparam int ADD_W   = 16;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_WAIT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POST  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd2;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_CLOSED   = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef struct packed {
        logic               we;
        logic [QADDR_W-1:0] addr;
        logic [ID_W-1:0]    data;
    } qram_wr_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        status_t         status;
        logic            last;
    } result_t;

    function automatic logic [QADDR_W-1:0] next_idx(input logic [QADDR_W-1:0] idx);
        logic [QADDR_W-1:0] nxt;
        if (idx == QADDR_W'(QDEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/core/csfw_qram.sv =====
// Waiter id queue storage: one write port, one read port, registered read data.
// Depends on csfw_pkg.
module csfw_qram (
    input  logic                             aclk,
    input  csfw_pkg::qram_wr_t               wr,
    input  logic [csfw_pkg::QADDR_W-1:0]     rd_addr,
    output logic [csfw_pkg::ID_W-1:0]        rd_data
);

    logic [csfw_pkg::ID_W-1:0] mem [csfw_pkg::QDEPTH];
    logic [csfw_pkg::ID_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/csfw_ctrl.sv =====
// Sequencer: unit counter, queue pointers and the per-item release loop.
// Depends on csfw_pkg and the assertion macro header; drives csfw_qram.
`include "counting_semaphore_fifo_waiters_unit_assert.svh"

module csfw_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [csfw_pkg::ACT_W-1:0]       s_action,
    input  logic [csfw_pkg::ID_W-1:0]        s_waiter_id,
    input  logic [csfw_pkg::ADD_W-1:0]       s_post_count,
    output logic                             res_valid,
    input  logic                             res_ready,
    output csfw_pkg::result_t                res,
    output csfw_pkg::qram_wr_t               wr,
    output logic [csfw_pkg::QADDR_W-1:0]     rd_addr,
    input  logic [csfw_pkg::ID_W-1:0]        rd_data
);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t                          state_reg, state_next;
    logic [csfw_pkg::ACT_W-1:0]      act_reg, act_next;
    logic [csfw_pkg::ID_W-1:0]       id_reg, id_next;
    logic [csfw_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [csfw_pkg::QADDR_W-1:0]    head_reg, head_next;
    logic [csfw_pkg::QADDR_W-1:0]    tail_reg, tail_next;
    logic [csfw_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [csfw_pkg::CNT_W:0]        sum;

    assign sum = {1'b0, count_reg} + {{(csfw_pkg::CNT_W + 1 - csfw_pkg::ADD_W){1'b0}}, s_post_count};

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        id_next    = id_reg;
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        wr         = '0;
        res_valid  = 1'b0;
        res        = '0;
        s_ready    = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    id_next    = s_waiter_id;
                    state_next = S_EXEC;
                    // saturate the counter on post
                    if (s_action == csfw_pkg::ACT_POST) begin
                        count_next = sum[csfw_pkg::CNT_W] ? '1 : sum[csfw_pkg::CNT_W-1:0];
                    end
                end
            end
            S_EXEC: begin
                case (act_reg)
                    csfw_pkg::ACT_WAIT: begin
                        if (res_ready) begin
                            res_valid  = 1'b1;
                            res.id     = id_reg;
                            res.last   = 1'b1;
                            state_next = S_IDLE;
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                                res.status = csfw_pkg::ST_GRANTED;
                            end else if (fill_reg != csfw_pkg::FILL_W'(csfw_pkg::QDEPTH)) begin
                                wr.we      = 1'b1;
                                wr.addr    = tail_reg;
                                wr.data    = id_reg;
                                tail_next  = csfw_pkg::next_idx(tail_reg);
                                fill_next  = fill_reg + 1'b1;
                                res.status = csfw_pkg::ST_QUEUED;
                            end else begin
                                res.status = csfw_pkg::ST_REJECTED;
                            end
                        end
                    end
                    csfw_pkg::ACT_POST: begin
                        if (count_reg != '0 && fill_reg != '0) begin
                            if (res_ready) begin
                                res_valid  = 1'b1;
                                res.id     = rd_data;
                                res.status = csfw_pkg::ST_GRANTED;
                                res.last   = (count_reg == csfw_pkg::CNT_W'(1)) ||
                                             (fill_reg == csfw_pkg::FILL_W'(1));
                                head_next  = csfw_pkg::next_idx(head_reg);
                                fill_next  = fill_reg - 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    csfw_pkg::ACT_CLOSE: begin
                        if (fill_reg != '0) begin
                            if (res_ready) begin
                                res_valid  = 1'b1;
                                res.id     = rd_data;
                                res.status = csfw_pkg::ST_CLOSED;
                                res.last   = (fill_reg == csfw_pkg::FILL_W'(1));
                                head_next  = csfw_pkg::next_idx(head_reg);
                                fill_next  = fill_reg - 1'b1;
                            end
                        end else begin
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        // undefined action: drop the word
                        state_next = S_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // prefetch the entry that will be the head next cycle
        rd_addr = head_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
        end
        act_reg <= act_next;
        id_reg  <= id_next;
    end

    `CSFW_ASSERT_ALWAYS(a_fill_bound, fill_reg <= csfw_pkg::FILL_W'(csfw_pkg::QDEPTH), "queue fill exceeds depth")
    `CSFW_ASSERT_IMPL(a_units_no_waiters, state_reg == S_IDLE && count_reg != '0, fill_reg == '0, "units available while waiters queued")
    `CSFW_ASSERT_IMPL(a_ptr_match, fill_reg == '0 || fill_reg == csfw_pkg::FILL_W'(csfw_pkg::QDEPTH), head_reg == tail_reg, "head and tail disagree with fill")

endmodule

// ===== rtl/core/counting_semaphore_fifo_waiters_unit.sv =====
// Counting semaphore with a FIFO queue of waiter ids; top level with output word register.
// The input word is registered in the sequencer, which then feeds the output word register.
// A new word is taken only when idle, after the last one is done; releases go one per cycle
// through the queue RAM's single read port, held while m_valid waits for m_ready.
// Reset: clears the unit count, queue pointers and output valid; queue RAM is left as is.
module counting_semaphore_fifo_waiters_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [csfw_pkg::ACT_W-1:0]       s_action,
    input  logic [csfw_pkg::ID_W-1:0]        s_waiter_id,
    input  logic [csfw_pkg::ADD_W-1:0]       s_post_count,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [csfw_pkg::ID_W-1:0]        m_granted_id,
    output logic [1:0]                       m_status,
    output logic                             m_last
);

    csfw_pkg::qram_wr_t              wr;
    logic [csfw_pkg::QADDR_W-1:0]    rd_addr;
    logic [csfw_pkg::ID_W-1:0]       rd_data;
    logic                            res_valid;
    logic                            res_ready;
    csfw_pkg::result_t               res;

    logic                            m_valid_reg;
    csfw_pkg::result_t               m_res_reg;

    csfw_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_waiter_id  (s_waiter_id),
        .s_post_count (s_post_count),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .wr           (wr),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    csfw_qram u_qram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // load a new word whenever the register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_granted_id = m_res_reg.id;
    assign m_status     = m_res_reg.status;
    assign m_last       = m_res_reg.last;

endmodule
